### rtl/msc_pkg.sv
package msc_pkg;

  localparam int DIM_BITS    = 16;
  localparam int LEVEL_W     = 5;
  localparam int CLASS_W     = 5;
  localparam int OFFSET_W    = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int BYTES_W     = 36;
  localparam int SUM_W       = BYTES_W + 1;
  localparam int PROD_W      = 2 * DIM_BITS;
  localparam int NUM_CLASSES = 20;

  // Dividend holds a dimension plus (footprint - 1), rounded up to an even width
  // because the divider retires two quotient bits per cycle.
  localparam int DVD_W       = ((DIM_BITS + 5) / 2) * 2;
  localparam int DIV_STEPS   = DVD_W / 2;
  localparam int STEP_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BASE_WIDTH    = 2'd0,
    CFG_BASE_HEIGHT   = 2'd1,
    CFG_FORMAT_CLASS  = 2'd2,
    CFG_PAYLOAD_BYTES = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    STATUS_OK            = 3'd0,
    STATUS_ZERO_DIM      = 3'd1,
    STATUS_BAD_FORMAT    = 3'd2,
    STATUS_NOT_ASCENDING = 3'd3,
    STATUS_EXCEEDS       = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_W,
    ST_DIV_H,
    ST_MUL,
    ST_SCALE,
    ST_CHECK
  } state_t;

  typedef struct packed {
    logic                first_level;
    logic [OFFSET_W-1:0] mip_offset;
  } req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  level_index;
    logic [DIM_BITS-1:0] level_width;
    logic [DIM_BITS-1:0] level_height;
    logic [BYTES_W-1:0]  level_bytes;
    status_t             status;
  } rsp_t;

  typedef struct packed {
    logic [3:0] bw;
    logic [3:0] bh;
    logic [2:0] bytes_shift;
  } footprint_t;

  typedef struct packed {
    logic             start;
    logic [3:0]       divisor;
    logic [DVD_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // Block footprint per format class; bytes per block are powers of two,
  // so they are kept as a shift amount.
  function automatic footprint_t footprint(input logic [CLASS_W-1:0] cls);
    footprint_t fp;
    case (cls)
      5'd0:    fp = '{bw: 4'd4,  bh: 4'd4,  bytes_shift: 3'd3};
      5'd1:    fp = '{bw: 4'd4,  bh: 4'd4,  bytes_shift: 3'd4};
      5'd2:    fp = '{bw: 4'd5,  bh: 4'd4,  bytes_shift: 3'd4};
      5'd3:    fp = '{bw: 4'd5,  bh: 4'd5,  bytes_shift: 3'd4};
      5'd4:    fp = '{bw: 4'd6,  bh: 4'd5,  bytes_shift: 3'd4};
      5'd5:    fp = '{bw: 4'd6,  bh: 4'd6,  bytes_shift: 3'd4};
      5'd6:    fp = '{bw: 4'd8,  bh: 4'd5,  bytes_shift: 3'd4};
      5'd7:    fp = '{bw: 4'd8,  bh: 4'd6,  bytes_shift: 3'd4};
      5'd8:    fp = '{bw: 4'd8,  bh: 4'd8,  bytes_shift: 3'd4};
      5'd9:    fp = '{bw: 4'd10, bh: 4'd5,  bytes_shift: 3'd4};
      5'd10:   fp = '{bw: 4'd10, bh: 4'd6,  bytes_shift: 3'd4};
      5'd11:   fp = '{bw: 4'd10, bh: 4'd8,  bytes_shift: 3'd4};
      5'd12:   fp = '{bw: 4'd10, bh: 4'd10, bytes_shift: 3'd4};
      5'd13:   fp = '{bw: 4'd12, bh: 4'd10, bytes_shift: 3'd4};
      5'd14:   fp = '{bw: 4'd12, bh: 4'd12, bytes_shift: 3'd4};
      5'd15:   fp = '{bw: 4'd1,  bh: 4'd1,  bytes_shift: 3'd0};
      5'd16:   fp = '{bw: 4'd1,  bh: 4'd1,  bytes_shift: 3'd1};
      5'd17:   fp = '{bw: 4'd1,  bh: 4'd1,  bytes_shift: 3'd2};
      5'd18:   fp = '{bw: 4'd1,  bh: 4'd1,  bytes_shift: 3'd3};
      5'd19:   fp = '{bw: 4'd1,  bh: 4'd1,  bytes_shift: 3'd4};
      default: fp = '{bw: 4'd1,  bh: 4'd1,  bytes_shift: 3'd0};
    endcase
    return fp;
  endfunction

endpackage

### rtl/msc_divider.sv
module msc_divider
  import msc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(DIV_STEPS - 1);

  logic                  busy;
  logic                  done;
  logic [STEP_CNT_W-1:0] cnt;
  logic [3:0]            divisor;
  logic [3:0]            rem;
  logic [DVD_W-1:0]      work;

  logic [4:0] t1, t2, r1, r2, dsr;
  logic       ge1, ge2;

  // Two restoring steps per cycle. The remainder stays below the divisor,
  // so four bits hold it between steps.
  always_comb begin
    dsr = {1'b0, divisor};
    t1  = {rem, work[DVD_W-1]};
    ge1 = (t1 >= dsr);
    r1  = ge1 ? (t1 - dsr) : t1;
    t2  = {r1[3:0], work[DVD_W-2]};
    ge2 = (t2 >= dsr);
    r2  = ge2 ? (t2 - dsr) : t2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      rem     <= '0;
      work    <= req.dividend;
    end else if (busy) begin
      rem  <= r2[3:0];
      work <= {work[DVD_W-3:0], ge1, ge2};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = work;

`ifndef ASSERT_OFF
  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider started while a division is in progress");
`endif

endmodule

### rtl/mip_upload_size_checker.sv
// Mip upload size checker.
// Configuration: write base width (index 0), base height (1), format class (2)
// and payload size in bytes (3) through cfg_we/cfg_index/cfg_data while idle.
// Request channel (req_valid/req_ready/req): one word per mip level, carrying
// the level's byte offset and a flag that restarts the level count at zero.
// Response channel (rsp_valid/rsp_ready/rsp): one word per request with the
// level index, level dimensions, level byte size and a status code.
// Sequence: a supported format runs the shared two-bit-per-cycle divider
// twice, once for the block columns and once for the block rows, followed
// by multiply, scale and check steps. An unsupported format skips the
// divider and goes straight to the check step.
// The response sits in an output register, so a new request is taken while
// the previous response waits. If the receiver stalls, the block holds in its
// check step until the output register frees up.
// Reset (rst, synchronous) restores the register defaults (1x1 texture,
// class 17, empty payload), the level count and the previous offset.
module mip_upload_size_checker
  import msc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  req_t                   req,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output rsp_t                   rsp
);

  logic [DIM_BITS-1:0] base_width;
  logic [DIM_BITS-1:0] base_height;
  logic [CLASS_W-1:0]  format_class;
  logic [OFFSET_W-1:0] payload_bytes;
  logic [LEVEL_W-1:0]  level_count;
  logic [OFFSET_W-1:0] previous_offset;

  state_t state, state_next;

  logic                req_fire;
  logic                div_start;
  logic                load_rsp;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic [LEVEL_W-1:0]  acc_level;
  logic [DIM_BITS-1:0] acc_w_shift, acc_h_shift, acc_w, acc_h;
  footprint_t          acc_fp;
  logic                acc_sup;

  logic [LEVEL_W-1:0]  lvl;
  logic [DIM_BITS-1:0] lw, lh;
  logic [OFFSET_W-1:0] off;
  footprint_t          fp_r;
  logic                zero_dim, bad_fmt, not_asc;
  logic [DIM_BITS-1:0] bx, by;
  logic [PROD_W-1:0]   prod;
  logic [BYTES_W-1:0]  bytes;
  logic [SUM_W-1:0]    end_sum;
  status_t             status_next;

  assign req_ready = (state == ST_IDLE);
  assign req_fire  = req_valid && req_ready;

  // Level dimensions and footprint for the word being taken.
  always_comb begin
    acc_level   = req.first_level ? '0 : level_count;
    acc_w_shift = base_width >> acc_level;
    acc_h_shift = base_height >> acc_level;
    acc_w       = (acc_w_shift == '0) ? DIM_BITS'(1) : acc_w_shift;
    acc_h       = (acc_h_shift == '0) ? DIM_BITS'(1) : acc_h_shift;
    acc_fp      = footprint(format_class);
    acc_sup     = (format_class < CLASS_W'(NUM_CLASSES));
  end

  // Ceiling division feeds the divider with dim + footprint - 1.
  always_comb begin
    div_req.start = div_start;
    if (state == ST_IDLE) begin
      div_req.divisor  = acc_fp.bw;
      div_req.dividend = DVD_W'(acc_w) + DVD_W'(acc_fp.bw) - DVD_W'(1);
    end else begin
      div_req.divisor  = fp_r.bh;
      div_req.dividend = DVD_W'(lh) + DVD_W'(fp_r.bh) - DVD_W'(1);
    end
  end

  msc_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    end_sum = SUM_W'(off) + SUM_W'(bytes);
    if (zero_dim) begin
      status_next = STATUS_ZERO_DIM;
    end else if (bad_fmt) begin
      status_next = STATUS_BAD_FORMAT;
    end else if (not_asc) begin
      status_next = STATUS_NOT_ASCENDING;
    end else if (end_sum > SUM_W'(payload_bytes)) begin
      status_next = STATUS_EXCEEDS;
    end else begin
      status_next = STATUS_OK;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    load_rsp   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          if (acc_sup) begin
            div_start  = 1'b1;
            state_next = ST_DIV_W;
          end else begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_DIV_W: begin
        if (div_rsp.done) begin
          div_start  = 1'b1;
          state_next = ST_DIV_H;
        end
      end
      ST_DIV_H: begin
        if (div_rsp.done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:   state_next = ST_SCALE;
      ST_SCALE: state_next = ST_CHECK;
      ST_CHECK: begin
        if (!rsp_valid || rsp_ready) begin
          load_rsp   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      rsp_valid       <= 1'b0;
      level_count     <= '0;
      previous_offset <= '0;
      base_width      <= DIM_BITS'(1);
      base_height     <= DIM_BITS'(1);
      format_class    <= CLASS_W'(17);
      payload_bytes   <= '0;
    end else begin
      state <= state_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (req_fire) begin
        previous_offset <= req.mip_offset;
        level_count     <= (acc_level == LEVEL_MAX) ? LEVEL_MAX : acc_level + 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_BASE_WIDTH:    base_width    <= cfg_data[DIM_BITS-1:0];
          CFG_BASE_HEIGHT:   base_height   <= cfg_data[DIM_BITS-1:0];
          CFG_FORMAT_CLASS:  format_class  <= cfg_data[CLASS_W-1:0];
          CFG_PAYLOAD_BYTES: payload_bytes <= cfg_data[OFFSET_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      lvl      <= acc_level;
      lw       <= acc_w;
      lh       <= acc_h;
      off      <= req.mip_offset;
      fp_r     <= acc_fp;
      zero_dim <= (base_width == '0) || (base_height == '0);
      bad_fmt  <= !acc_sup;
      not_asc  <= (acc_level != '0) && (req.mip_offset < previous_offset);
      bytes    <= '0;
    end
    if (state == ST_DIV_W && div_rsp.done) begin
      bx <= div_rsp.quotient[DIM_BITS-1:0];
    end
    if (state == ST_DIV_H && div_rsp.done) begin
      by <= div_rsp.quotient[DIM_BITS-1:0];
    end
    if (state == ST_MUL) begin
      prod <= PROD_W'(bx) * PROD_W'(by);
    end
    if (state == ST_SCALE) begin
      bytes <= BYTES_W'(prod) << fp_r.bytes_shift;
    end
    if (load_rsp) begin
      rsp.level_index  <= lvl;
      rsp.level_width  <= lw;
      rsp.level_height <= lh;
      rsp.level_bytes  <= bytes;
      rsp.status       <= status_next;
    end
  end

`ifndef ASSERT_OFF
  a_level_saturates: assert property (@(posedge clk) disable iff (rst)
    (req_fire && !req.first_level && level_count == LEVEL_MAX) |=> (level_count == LEVEL_MAX))
    else $error("level count wrapped past its maximum");
`endif

`ifndef ASSERT_OFF
  a_div_done_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV_W || state == ST_DIV_H))
    else $error("divider finished outside a division step");
`endif

`ifndef ASSERT_OFF
  a_bad_format_no_bytes: assert property (@(posedge clk) disable iff (rst)
    (load_rsp && bad_fmt) |-> (bytes == '0))
    else $error("unsupported format produced a nonzero byte count");
`endif

endmodule
